// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  // Fixed field widths
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned BLK_W  = 12;
  localparam int unsigned STAT_W = 2;

  // Full flags examined per scan cycle
  localparam int unsigned FLAG_CHUNK = 32;

  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RESET = 13'd4096;

  // Register indexes
  localparam logic REG_TOTAL_BLOCKS = 1'b0;

  // Request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd2;

  // Where the result of a transaction comes from
  typedef enum logic [1:0] {
    SRC_MODIFY,
    SRC_NONE,
    SRC_IGN
  } bba_src_e;

  typedef struct packed {
    logic     load;      // capture an accepted request
    logic     clr;       // write one word of the post-reset clearing pass
    logic     scan;      // examine one chunk of full flags
    logic     rd;        // read the selected bitmap word
    logic     wr;        // write back the modified word
    logic     out_load;  // load the result register
    bba_src_e out_src;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic free_req;
    logic free_ok;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } bba_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_cfg.sv =====
`default_nettype none

module bba_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [bba_pkg::CFG_W-1:0]   total_o
);
  import bba_pkg::*;

  logic             wr_en;
  logic [CFG_W-1:0] total_q;
  logic [CFG_W-1:0] total_d;

  // paddr[1:0] is the byte offset within the word
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_TOTAL_BLOCKS);

  always_comb begin
    total_d = total_q;
    if (wr_en) begin
      total_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_BLOCKS_RESET;
    end else begin
      total_q <= total_d;
    end
  end

  assign prdata  = (paddr[2] == REG_TOTAL_BLOCKS) ? {{(32 - CFG_W){1'b0}}, total_q} : 32'd0;
  assign pready  = 1'b1;
  assign total_o = total_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t      cmd_o
);
  import bba_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_MODIFY = 3'd4;
  localparam logic [2:0] S_NONE   = 3'd5;
  localparam logic [2:0] S_IGN    = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_src = SRC_MODIFY;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.free_req) begin
            state_d = S_SCAN;
          end else if (sts_i.free_ok) begin
            state_d = S_READ;
          end else begin
            state_d = S_IGN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_READ;
        end else if (sts_i.scan_last) begin
          state_d = S_NONE;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MODIFY;
      end
      S_MODIFY: begin
        // write-back and result load happen together, once the result slot is free
        if (sts_i.out_free) begin
          cmd_o.wr       = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_NONE: begin
        cmd_o.out_src = SRC_NONE;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_IGN: begin
        cmd_o.out_src = SRC_IGN;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
`default_nettype none

// WORD_BITS must be a power of two.
module bba_dp #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bba_pkg::bba_cmd_t            cmd_i,
  output bba_pkg::bba_sts_t                 sts_o,
  input  wire logic [bba_pkg::CFG_W-1:0]    total_i,
  input  wire logic                         func_i,
  input  wire logic [bba_pkg::BLK_W-1:0]    block_number_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic      [bba_pkg::BLK_W-1:0]    granted_block_o,
  output logic      [bba_pkg::STAT_W-1:0]   status_o
);
  import bba_pkg::*;

  localparam int unsigned NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned IDX_W      = WIDX_W + BIT_W;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMP_A      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int unsigned CMP_B      = (CMP_A > IDX_W) ? CMP_A : IDX_W;
  localparam int unsigned CMP_W      = (CMP_B > BLK_W) ? CMP_B : BLK_W;
  localparam int unsigned NUM_CHUNKS = (NUM_WORDS + FLAG_CHUNK - 1) / FLAG_CHUNK;
  localparam int unsigned CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned CPOS_W     = $clog2(FLAG_CHUNK);
  localparam int unsigned SCAN_W     = CHUNK_W + CPOS_W;
  localparam int unsigned PAD_W      = NUM_CHUNKS * FLAG_CHUNK;

  // Bitmap storage and full flags
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [NUM_WORDS-1:0] full_q;

  // Request and walk state
  logic                 func_q;
  logic [BIT_W-1:0]     bsel_q;
  logic [WIDX_W-1:0]    widx_q;
  logic [CHUNK_W-1:0]   chunk_q;
  logic [WIDX_W-1:0]    clr_addr_q;

  // Result register
  logic                 out_valid_q;
  logic [BLK_W-1:0]     gblk_q;
  logic [STAT_W-1:0]    stat_q;

  logic [CMP_W-1:0]     count;
  logic [CMP_W-1:0]     total_ext;
  logic [CMP_W-1:0]     blk_ext;
  logic [PAD_W-1:0]     flags_pad;
  logic [FLAG_CHUNK-1:0] chunk_flags;
  logic [CPOS_W-1:0]    hit_pos;
  logic [SCAN_W-1:0]    scan_idx;
  logic [BIT_W-1:0]     zpos;
  logic [IDX_W-1:0]     alloc_idx;
  logic [CMP_W-1:0]     alloc_ext;
  logic                 fits;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;
  logic                 do_write;
  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [BLK_W-1:0]     gblk_d;
  logic [STAT_W-1:0]    stat_d;

  // Counts above capacity act as capacity
  assign total_ext = CMP_W'(total_i);
  assign count     = (total_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : total_ext;
  assign blk_ext   = CMP_W'(block_number_i);

  // Flag scan: one chunk a cycle, missing words count as full
  always_comb begin
    flags_pad                = '1;
    flags_pad[NUM_WORDS-1:0] = full_q;
  end

  assign chunk_flags = flags_pad[{chunk_q, CPOS_W'(0)} +: FLAG_CHUNK];

  always_comb begin
    hit_pos = '0;
    for (int i = FLAG_CHUNK - 1; i >= 0; i--) begin
      if (!chunk_flags[i]) begin
        hit_pos = CPOS_W'(i);
      end
    end
  end

  assign scan_idx = {chunk_q, hit_pos};

  // Lowest clear bit of the fetched word
  always_comb begin
    zpos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata_q[i]) begin
        zpos = BIT_W'(i);
      end
    end
  end

  assign alloc_idx = {widx_q, zpos};
  assign alloc_ext = CMP_W'(alloc_idx);
  assign fits      = (alloc_ext < count);
  assign bit_mask  = WORD_BITS'(1) << ((func_q == FUNC_FREE) ? bsel_q : zpos);
  assign new_word  = (func_q == FUNC_FREE) ? (rdata_q & ~bit_mask) : (rdata_q | bit_mask);
  assign do_write  = cmd_i.wr && ((func_q == FUNC_FREE) || fits);

  assign mem_we    = cmd_i.clr || do_write;
  assign mem_waddr = cmd_i.clr ? clr_addr_q : widx_q;
  assign mem_wdata = cmd_i.clr ? ((clr_addr_q == '0) ? WORD_BITS'(1) : '0) : new_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[widx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q     <= '0;
      clr_addr_q <= '0;
    end else begin
      if (do_write) begin
        full_q[widx_q] <= &new_word;
      end
      if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      bsel_q  <= block_number_i[BIT_W-1:0];
      widx_q  <= blk_ext[BIT_W +: WIDX_W];
      chunk_q <= '0;
    end else if (cmd_i.scan) begin
      if (~&chunk_flags) begin
        widx_q <= scan_idx[WIDX_W-1:0];
      end else begin
        chunk_q <= chunk_q + CHUNK_W'(1);
      end
    end
  end

  // Result selection
  always_comb begin
    gblk_d = '0;
    stat_d = STAT_IGNORED;
    case (cmd_i.out_src)
      SRC_MODIFY: begin
        if (func_q == FUNC_FREE) begin
          stat_d = STAT_DONE;
        end else if (fits) begin
          gblk_d = alloc_ext[BLK_W-1:0];
          stat_d = STAT_DONE;
        end else begin
          stat_d = STAT_NONE_FREE;
        end
      end
      SRC_NONE: begin
        stat_d = STAT_NONE_FREE;
      end
      SRC_IGN: begin
        stat_d = STAT_IGNORED;
      end
      default: begin
        stat_d = STAT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      gblk_q <= gblk_d;
      stat_q <= stat_d;
    end
  end

  always_comb begin
    sts_o.clr_last  = (clr_addr_q == WIDX_W'(NUM_WORDS - 1));
    sts_o.free_req  = (func_i == FUNC_FREE);
    sts_o.free_ok   = (block_number_i != '0) && (blk_ext < count);
    sts_o.scan_hit  = ~&chunk_flags;
    sts_o.scan_last = (chunk_q == CHUNK_W'(NUM_CHUNKS - 1));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = gblk_q;
  assign status_o        = stat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    func_i, block_number_i
// out       source     out_valid_o / out_stall_i  granted_block_o, status_o
// cfg       APB slave  psel, penable, pwrite      paddr, pwdata, prdata
//
// Allocate: scans 1 to ceil(MAX_BLOCKS / WORD_BITS / 32) flag chunks (1 to
// 4 at the defaults). At most one bitmap memory read and one write per
// request. After reset a clearing pass over the MAX_BLOCKS / WORD_BITS
// bitmap words (128 at the defaults) initialises the bitmap memory;
// in_stall_o is high meanwhile. A result waiting in the output register
// does not block acceptance; only the final result load, with any
// write-back, stalls while out_stall_i holds the previous result.
module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [bba_pkg::BLK_W-1:0]     block_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [bba_pkg::BLK_W-1:0]     granted_block_o,
  output logic      [bba_pkg::STAT_W-1:0]    status_o
);
  import bba_pkg::*;

  logic [CFG_W-1:0] total;
  bba_cmd_t         cmd;
  bba_sts_t         sts;

  bba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .total_o (total)
  );

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .total_i         (total),
    .func_i          (func_i),
    .block_number_i  (block_number_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .granted_block_o (granted_block_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  import bba_pkg::*;

  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned NUM_WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam logic [2:0]  TOTAL_BLOCKS_ADDR = 3'(4 * REG_TOTAL_BLOCKS);
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct {
    logic [BLK_W-1:0]  granted;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  // Mirror of the allocator: used bits per word, per-word full flags, block count
  class alloc_scoreboard;
    logic [WORD_BITS-1:0] used_words [NUM_WORDS];
    bit                   word_full  [NUM_WORDS];
    logic [CFG_W-1:0]     block_total;
    alloc_result_t        pending_grants [$];
    int unsigned          fail_count;

    function new();
      foreach (used_words[w]) begin
        used_words[w] = '0;
        word_full[w]  = 1'b0;
      end
      used_words[0] = 1;
      block_total   = TOTAL_BLOCKS_RESET;
      fail_count    = 0;
    endfunction

    function void set_block_total(logic [CFG_W-1:0] v);
      block_total = v;
    endfunction

    function alloc_result_t note_request(logic f, logic [BLK_W-1:0] blk);
      alloc_result_t r;
      int unsigned   limit;
      int unsigned   idx;
      int unsigned   w;
      int unsigned   b;
      bit            searched;
      r.granted = '0;
      r.status  = STAT_DONE;
      limit = (block_total > MAX_BLOCKS) ? MAX_BLOCKS : block_total;
      if (f == FUNC_ALLOC) begin
        r.status = STAT_NONE_FREE;
        searched = 1'b0;
        for (int i = 0; i < NUM_WORDS && !searched; i++) begin
          if (!word_full[i]) begin
            // first word with a clear bit decides, granted or not
            searched = 1'b1;
            b = 0;
            while (used_words[i][b]) b++;
            idx = i * WORD_BITS + b;
            if (idx < limit) begin
              used_words[i][b] = 1'b1;
              word_full[i]     = &used_words[i];
              r.granted        = idx[BLK_W-1:0];
              r.status         = STAT_DONE;
            end
          end
        end
      end else if (blk == 0 || blk >= limit) begin
        r.status = STAT_IGNORED;
      end else begin
        w = blk / WORD_BITS;
        b = blk % WORD_BITS;
        used_words[w][b] = 1'b0;
        word_full[w]     = 1'b0;
      end
      pending_grants.push_back(r);
      return r;
    endfunction

    function void check_result(logic [BLK_W-1:0] g, logic [STAT_W-1:0] s);
      alloc_result_t e;
      if (pending_grants.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: block %0d status %0d", g, s);
      end else begin
        e = pending_grants.pop_front();
        if (g !== e.granted || s !== e.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected block %0d status %0d, got block %0d status %0d",
                     e.granted, e.status, g, s);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction

    function int unsigned failures();
      return fail_count;
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [BLK_W-1:0]  block_number_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [BLK_W-1:0]  granted_block_o;
  logic [STAT_W-1:0] status_o;

  alloc_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     useful_items;
  int unsigned     stall_mode;
  int unsigned     stall_left = 0;

  bitmap_block_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .block_number_i  (block_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_block_o (granted_block_o),
    .status_o        (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall pattern: free-running, quiet, choppy or long runs
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: begin
        if ($urandom_range(0, 7) == 0) out_stall_i <= !out_stall_i;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(granted_block_o, status_o);
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sb.set_block_total(data[CFG_W-1:0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_request(input logic f, input logic [BLK_W-1:0] blk);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i     = 1'b1;
    func_i         = f;
    block_number_i = blk;
    burst_left--;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    void'(sb.note_request(f, blk));
    useful_items++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] v);
    end_burst();
    wait_idle();
    apb_write(TOTAL_BLOCKS_ADDR, {{(32-CFG_W){1'b0}}, v});
  endtask

  initial begin
    logic [CFG_W-1:0] blocks;
    int unsigned      limit;
    int unsigned      phase_len;
    int unsigned      alloc_pct;
    int unsigned      pick;
    int unsigned      hi;
    int unsigned      lo;
    logic [BLK_W-1:0] blk;

    sb             = new();
    burst_left     = 0;
    useful_items   = 0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_ALLOC;
    block_number_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero count: nothing to grant, every free ignored
    reconfigure(13'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_FREE, 12'd0);

    // count of one covers only the reserved block
    reconfigure(13'd1);
    send_request(FUNC_ALLOC, 12'd4095);
    send_request(FUNC_FREE, 12'd0);

    reconfigure(13'd3);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd2);
    send_request(FUNC_FREE, 12'd2);    // already clear
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd3);    // at the count
    send_request(FUNC_FREE, 12'd4095);

    // above capacity acts as full capacity
    reconfigure(13'd8191);
    send_request(FUNC_ALLOC, 12'd4095);
    send_request(FUNC_FREE, 12'd4095);
    send_request(FUNC_FREE, 12'd0);
    send_request(FUNC_ALLOC, 12'd2730);

    reconfigure(TOTAL_BLOCKS_RESET);
    send_request(FUNC_ALLOC, 12'd1365);
    send_request(FUNC_FREE, 12'd3);
    send_request(FUNC_ALLOC, 12'd0);

    // random phases, mostly small counts so the bitmap fills and drains;
    // bits left above a lowered count stay put across phases
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      blocks = CFG_W'($urandom_range(1, 80));
      else if (pick < 75) blocks = CFG_W'($urandom_range(81, 300));
      else if (pick < 85) blocks = CFG_W'($urandom_range(0, 2));
      else if (pick < 92) blocks = CFG_W'($urandom_range(4097, 8191));
      else                blocks = CFG_W'(MAX_BLOCKS);
      reconfigure(blocks);
      limit     = (blocks > MAX_BLOCKS) ? MAX_BLOCKS : blocks;
      phase_len = $urandom_range(40, 160);
      alloc_pct = $urandom_range(30, 85);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_request(FUNC_ALLOC, BLK_W'($urandom_range(0, 4095)));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 65) begin
            hi  = (limit > 1) ? limit - 1 : 1;
            blk = BLK_W'($urandom_range(1, hi));
          end else if (pick < 80) begin
            lo  = limit;
            hi  = (limit + 8 > 4095) ? 4095 : limit + 8;
            blk = (lo > 4095) ? '0 : BLK_W'($urandom_range(lo, hi));
          end else if (pick < 85) begin
            blk = '0;
          end else begin
            blk = BLK_W'($urandom_range(0, 4095));
          end
          send_request(FUNC_FREE, blk);
        end
      end
    end

    end_burst();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("results never delivered: %0d", sb.pending());
    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
